// File: rtl/pct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// shared types and codes of the plateau charge terminator
// ----------------------------------------------------------------------------
package pct_pkg;

   localparam int VOLT_W   = 16;
   localparam int TIMER_W  = 16;
   localparam int CYCLE_W  = 8;
   localparam int CODE_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CYCLES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TICKS = 1'd1;

   localparam logic [CYCLE_W-1:0] MIN_CYCLES_RST   = 8'd3;
   localparam logic [TIMER_W-1:0] PERIOD_TICKS_RST = 16'd1000;

   // battery status
   localparam logic [CODE_W-1:0] ST_DISCHARGED = 2'd0;
   localparam logic [CODE_W-1:0] ST_CHARGING   = 2'd1;
   localparam logic [CODE_W-1:0] ST_CHARGED    = 2'd2;

   // charger switch command
   localparam logic [CODE_W-1:0] CMD_NONE = 2'd0;
   localparam logic [CODE_W-1:0] CMD_ON   = 2'd1;
   localparam logic [CODE_W-1:0] CMD_OFF  = 2'd2;

   // indication
   localparam logic [CODE_W-1:0] LED_NONE     = 2'd0;
   localparam logic [CODE_W-1:0] LED_CHARGING = 2'd1;
   localparam logic [CODE_W-1:0] LED_CHARGED  = 2'd2;
   localparam logic [CODE_W-1:0] LED_STANDBY  = 2'd3;

   typedef struct packed {
      logic [VOLT_W-1:0] solar_volts;
      logic [VOLT_W-1:0] battery_volts;
      logic [CODE_W-1:0] status_in;
      logic              overheat;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] status_out;
      logic [CODE_W-1:0] charge_cmd;
      logic [CODE_W-1:0] led_mode;
   } rsp_type;

   typedef struct packed {
      logic [CYCLE_W-1:0] min_cycles;
      logic [TIMER_W-1:0] period_ticks;
   } cfg_type;

endpackage

// File: rtl/plateau_charge_terminator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plateau_charge_terminator
// ends battery charging once the battery voltage stops rising
// ----------------------------------------------------------------------------
// One req beat is one control tick carrying a solar and a battery voltage
// sample, the present battery status and an overheat flag; each tick gives
// exactly one rsp beat with the new status, the charger command and the led
// mode. A beat is taken every clock cycle while req_stall is low: the tick
// goes into an input register and, once it moves on, the state update in
// pct_core (saturating tick timer, peak voltage, cycle count) writes the
// result register, so a tick passes the input register and then the result
// register before rsp valid. The result register parts the two sides: a new
// tick is taken as long as the result register is empty or is being drained
// in the same cycle. The user must write the csr registers (min_cycles,
// period_ticks) only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module plateau_charge_terminator (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pct_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pct_pkg::rsp_type                rsp_data,
   // configuration port
   input  logic                            csr_write_en,
   input  logic [pct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pct_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pct_pkg::*;

   cfg_type cfg;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;

   logic req_accept;
   logic advance;

   // the input stage moves on when the result register is free or drains now
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   pct_cfg u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // state commits only when the tick moves into the result register
   pct_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/pct_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_cfg
// configuration registers, written through the csr port
// ----------------------------------------------------------------------------
module pct_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [pct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pct_pkg::cfg_type                cfg
);
   import pct_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_CYCLES:   cfg_in.min_cycles   = csr_wdata[CYCLE_W-1:0];
            CSR_PERIOD_TICKS: cfg_in.period_ticks = csr_wdata[TIMER_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_cycles   <= MIN_CYCLES_RST;
         cfg_ff.period_ticks <= PERIOD_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_core
// charge state (timer, peak, cycle count) and the per-tick decision
// ----------------------------------------------------------------------------
module pct_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pct_pkg::req_type  item,
   input  pct_pkg::cfg_type  cfg,
   output pct_pkg::rsp_type  result
);
   import pct_pkg::*;

   logic [TIMER_W-1:0] tick_timer_ff, tick_timer_in;
   logic [VOLT_W-1:0]  peak_volts_ff, peak_volts_in;
   logic [CYCLE_W-1:0] cycle_count_ff, cycle_count_in;

   always_comb begin
      logic [TIMER_W-1:0] timer_inc;
      logic [CYCLE_W-1:0] cycle_inc;
      logic               period_done;
      logic               new_peak;
      logic               terminate;

      tick_timer_in  = tick_timer_ff;
      peak_volts_in  = peak_volts_ff;
      cycle_count_in = cycle_count_ff;
      result.status_out = item.status_in;
      result.charge_cmd = CMD_NONE;
      result.led_mode   = LED_NONE;

      timer_inc = (tick_timer_ff == {TIMER_W{1'b1}}) ? tick_timer_ff
                                                      : tick_timer_ff + 1'b1;
      cycle_inc = (cycle_count_ff == {CYCLE_W{1'b1}}) ? cycle_count_ff
                                                       : cycle_count_ff + 1'b1;
      period_done = (timer_inc >= cfg.period_ticks);
      new_peak    = period_done && (item.battery_volts > peak_volts_ff);
      // after a new peak the timer restarts, so only a zero period ends it again
      terminate   = (new_peak ? (cfg.period_ticks == '0) : period_done) &&
                    ((new_peak ? cycle_inc : cycle_count_ff) >= cfg.min_cycles);

      if (!item.overheat) begin
         if (item.battery_volts < item.solar_volts) begin
            if (item.status_in == ST_DISCHARGED || item.status_in == ST_CHARGING) begin
               result.charge_cmd = CMD_ON;
               result.led_mode   = LED_CHARGING;
               tick_timer_in     = timer_inc;
               if (new_peak) begin
                  tick_timer_in  = '0;
                  peak_volts_in  = item.battery_volts;
                  cycle_count_in = cycle_inc;
               end
               if (terminate) begin
                  result.status_out = ST_CHARGED;
                  result.charge_cmd = CMD_OFF;
                  result.led_mode   = LED_CHARGED;
                  tick_timer_in     = '0;
                  peak_volts_in     = '0;
                  cycle_count_in    = '0;
               end
            end else if (item.status_in == ST_CHARGED) begin
               result.charge_cmd = CMD_OFF;
               result.led_mode   = LED_CHARGED;
               tick_timer_in     = '0;
               peak_volts_in     = '0;
               cycle_count_in    = '0;
            end
         end else begin
            result.led_mode = LED_STANDBY;
            tick_timer_in   = '0;
            peak_volts_in   = '0;
            cycle_count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_timer_ff  <= '0;
         peak_volts_ff  <= '0;
         cycle_count_ff <= '0;
      end else if (fire) begin
         tick_timer_ff  <= tick_timer_in;
         peak_volts_ff  <= peak_volts_in;
         cycle_count_ff <= cycle_count_in;
      end
   end

endmodule

// File: rtl/pct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_checker
// port-level checks of the plateau charge terminator
// ----------------------------------------------------------------------------
module pct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input pct_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input pct_pkg::rsp_type                rsp_data
);
   import pct_pkg::*;

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled tick beat is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled req beat changed");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // switching off always goes with charged status and charged led
   a_off_charged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.charge_cmd == CMD_OFF |->
      rsp_data.status_out == ST_CHARGED && rsp_data.led_mode == LED_CHARGED)
      else $error("charger off without charged status");

   // standby never commands the charger
   a_standby_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.led_mode == LED_STANDBY |->
      rsp_data.charge_cmd == CMD_NONE)
      else $error("charger command in standby");

endmodule

bind plateau_charge_terminator pct_checker u_pct_checker (.*);

// File: tb/pct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_scoreboard
// watches the tick and result channels and scores every result beat
// ----------------------------------------------------------------------------
// Follows the csr writes and carries its own copy of the charge session
// (tick timer, peak voltage, completed periods). Each accepted tick is turned
// into the expected status, charger command and led mode. Each accepted
// result beat is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module pct_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  pct_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  pct_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_en,
   input  logic [pct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pct_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              open_ticks
);
   import pct_pkg::*;

   logic [CYCLE_W-1:0] min_cycles_q = MIN_CYCLES_RST;
   logic [TIMER_W-1:0] period_q     = PERIOD_TICKS_RST;

   logic [TIMER_W-1:0] timer_q  = '0;
   logic [VOLT_W-1:0]  peak_q   = '0;
   logic [CYCLE_W-1:0] cycles_q = '0;

   int mismatch_count = 0;
   int open_count     = 0;

   rsp_type status_forecast[$];

   assign mismatches = mismatch_count;
   assign open_ticks = open_count;

   function automatic void clear_session();
      timer_q  = '0;
      peak_q   = '0;
      cycles_q = '0;
   endfunction

   // one control tick: updates the session copy and gives the expected beat
   function automatic rsp_type forecast_tick(input req_type tick);
      rsp_type            res;
      logic [CODE_W-1:0]  status;
      status         = tick.status_in;
      res.charge_cmd = CMD_NONE;
      res.led_mode   = LED_NONE;
      if (!tick.overheat) begin
         if (tick.battery_volts < tick.solar_volts) begin
            if (status == ST_DISCHARGED || status == ST_CHARGING) begin
               res.charge_cmd = CMD_ON;
               res.led_mode   = LED_CHARGING;
               if (timer_q != '1)
                  timer_q = timer_q + 1'b1;
               if (timer_q >= period_q && tick.battery_volts > peak_q) begin
                  peak_q  = tick.battery_volts;
                  timer_q = '0;
                  if (cycles_q != '1)
                     cycles_q = cycles_q + 1'b1;
               end
               if (timer_q >= period_q && peak_q >= tick.battery_volts &&
                   cycles_q >= min_cycles_q) begin
                  status         = ST_CHARGED;
                  res.charge_cmd = CMD_OFF;
                  res.led_mode   = LED_CHARGED;
                  clear_session();
               end
            end else if (status == ST_CHARGED) begin
               res.charge_cmd = CMD_OFF;
               res.led_mode   = LED_CHARGED;
               clear_session();
            end
         end else begin
            clear_session();
            res.led_mode = LED_STANDBY;
         end
      end
      res.status_out = status;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         min_cycles_q = MIN_CYCLES_RST;
         period_q     = PERIOD_TICKS_RST;
         clear_session();
         status_forecast.delete();
         open_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MIN_CYCLES:   min_cycles_q = csr_wdata[CYCLE_W-1:0];
               CSR_PERIOD_TICKS: period_q     = csr_wdata[TIMER_W-1:0];
               default: ;
            endcase
         end
         // result beat first: it always belongs to an older tick
         if (rsp_valid && !rsp_stall) begin
            if (status_forecast.size() == 0) begin
               if (mismatch_count < 10)
                  $display({"pct_scoreboard: %0t: result beat with no tick open: ",
                            "status %0d cmd %0d led %0d"},
                           $realtime, rsp_data.status_out, rsp_data.charge_cmd,
                           rsp_data.led_mode);
               mismatch_count++;
            end else begin
               want = status_forecast.pop_front();
               if (want.status_out != rsp_data.status_out ||
                   want.charge_cmd != rsp_data.charge_cmd ||
                   want.led_mode != rsp_data.led_mode) begin
                  if (mismatch_count < 10)
                     $display({"pct_scoreboard: %0t: expected status %0d cmd %0d ",
                               "led %0d, got status %0d cmd %0d led %0d"},
                              $realtime, want.status_out, want.charge_cmd,
                              want.led_mode, rsp_data.status_out,
                              rsp_data.charge_cmd, rsp_data.led_mode);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            status_forecast.push_back(forecast_tick(req_data));
         open_count <= status_forecast.size();
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the plateau charge terminator
// ----------------------------------------------------------------------------
// A directed opening covers the voltage extremes, every battery status, the
// overheat freeze, no solar surplus and the zero period. Random phases then
// run charge sessions (battery ramps with plateaus) under several csr
// settings, with some noise ticks mixed in. A long steady climb drives the
// cycle count into saturation. Scoring is done by pct_scoreboard.
// ----------------------------------------------------------------------------
module tb;
   import pct_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          RANDOM_PHASES   = 8;
   localparam int          TICKS_PER_PHASE = 80;
   // status code outside the defined set, passed through by the block
   localparam logic [CODE_W-1:0] ST_UNDEFINED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = CSR_MIN_CYCLES;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   int mismatches;
   int open_ticks;

   // set per phase: both sides run without gaps while it is high, but for the long hold-offs
   bit no_idle = 1'b0;

   // charge session shape for the random part
   int unsigned ramp_level;
   int          plateau_left;

   always #1 clock = ~clock;

   plateau_charge_terminator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pct_scoreboard u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .open_ticks   (open_ticks)
   );

   function automatic req_type tick_of(input logic [VOLT_W-1:0] solar,
                                       input logic [VOLT_W-1:0] batt,
                                       input logic [CODE_W-1:0] status,
                                       input logic hot);
      req_type t;
      t.solar_volts   = solar;
      t.battery_volts = batt;
      t.status_in     = status;
      t.overheat      = hot;
      return t;
   endfunction

   // offer one tick beat, after a random gap, and wait until it is taken;
   // valid stays high when the next beat follows without a gap
   task automatic send_tick(input req_type tick);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every tick has its result beat
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_ticks != 0) @(posedge clock);
      // pipe of an input and a result register, then spare clocks
      repeat (4) @(posedge clock);
   endtask

   // csr writes only with the block idle
   task automatic apply_config(input logic [CYCLE_W-1:0] min_cycles,
                               input logic [TIMER_W-1:0] period_ticks);
      settle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MIN_CYCLES;
      csr_wdata    <= CSR_DATA_W'(min_cycles);
      @(posedge clock);
      csr_index    <= CSR_PERIOD_TICKS;
      csr_wdata    <= CSR_DATA_W'(period_ticks);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // mostly a charge session: battery creeps up, stalls on plateaus, solar
   // mostly above it; the rest is noise over the full field ranges
   task automatic next_tick(output req_type tick);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         tick.solar_volts   = VOLT_W'($urandom);
         tick.battery_volts = VOLT_W'($urandom);
         tick.status_in     = CODE_W'($urandom);
         tick.overheat      = 1'($urandom);
      end else begin
         if (plateau_left > 0)
            plateau_left--;
         else if ($urandom_range(0, 9) == 0)
            plateau_left = $urandom_range(1, 20);
         else
            ramp_level += $urandom_range(1, 3);
         if (ramp_level > 65000)
            ramp_level = $urandom_range(0, 1000);
         tick.battery_volts = VOLT_W'(ramp_level);
         // occasional loss of solar surplus
         if ($urandom_range(0, 19) == 0)
            tick.solar_volts = VOLT_W'($urandom_range(0, ramp_level));
         else
            tick.solar_volts = VOLT_W'(ramp_level + $urandom_range(1, 500));
         roll = $urandom_range(0, 99);
         if (roll < 45)
            tick.status_in = ST_CHARGING;
         else if (roll < 88)
            tick.status_in = ST_DISCHARGED;
         else if (roll < 97)
            tick.status_in = ST_CHARGED;
         else
            tick.status_in = ST_UNDEFINED;
         tick.overheat = ($urandom_range(0, 29) == 0);
      end
   endtask

   // result side: random stall before each beat, two long hold-offs so the
   // block fills up and pushes back on the tick side
   initial begin
      int          stall_len;
      int unsigned beats;
      beats = 0;
      while (reset) @(posedge clock);
      forever begin
         if (beats == 300 || beats == 700)
            stall_len = 60;
         else
            stall_len = no_idle ? 0 : $urandom_range(0, 6);
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats++;
      end
   end

   // watchdog
   initial begin
      int unsigned elapsed;
      elapsed = 0;
      while (elapsed < CYCLE_LIMIT) begin
         @(posedge clock);
         elapsed++;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      req_type     t;
      int unsigned k;
      int          p;
      ramp_level   = 1000;
      plateau_left = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: min 3 periods, 1000 ticks per period
      send_tick(tick_of(16'hFFFF, 16'h0000, ST_DISCHARGED, 1'b0));
      send_tick(tick_of(16'hFFFF, 16'hFFFE, ST_CHARGING, 1'b0));
      send_tick(tick_of(16'h0000, 16'h0000, ST_CHARGING, 1'b0));   // equal, no surplus
      send_tick(tick_of(16'd100, 16'd100, ST_DISCHARGED, 1'b0));
      send_tick(tick_of(16'h0000, 16'hFFFF, ST_CHARGED, 1'b0));    // standby keeps status
      send_tick(tick_of(16'hFFFF, 16'h0000, ST_CHARGED, 1'b0));    // charged: switch off
      send_tick(tick_of(16'hFFFF, 16'h0000, ST_UNDEFINED, 1'b0));  // undefined status
      send_tick(tick_of(16'h0000, 16'hFFFF, ST_UNDEFINED, 1'b0));
      send_tick(tick_of(16'hFFFF, 16'h0000, ST_CHARGING, 1'b1));   // overheat freeze
      send_tick(tick_of(16'h0000, 16'hFFFF, ST_UNDEFINED, 1'b1));
      send_tick(tick_of(16'hFFFF, 16'h0001, ST_CHARGING, 1'b0));

      // zero period: new peak and termination in one tick
      apply_config(8'd0, 16'd0);
      send_tick(tick_of(16'd200, 16'd100, ST_CHARGING, 1'b0));
      send_tick(tick_of(16'hFFFF, 16'hFFFE, ST_DISCHARGED, 1'b0));
      send_tick(tick_of(16'd50, 16'd0, ST_CHARGING, 1'b0));

      // one tick per period: two peaks then a plateau ends the charge
      apply_config(8'd1, 16'd1);
      send_tick(tick_of(16'd1000, 16'd10, ST_CHARGING, 1'b0));
      send_tick(tick_of(16'd1000, 16'd20, ST_CHARGING, 1'b0));
      send_tick(tick_of(16'd1000, 16'd20, ST_CHARGING, 1'b0));
      send_tick(tick_of(16'd1000, 16'd15, ST_DISCHARGED, 1'b0));
      send_tick(tick_of(16'd1000, 16'd15, ST_CHARGING, 1'b1));

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       apply_config(8'd2, 16'd3);
            1:       apply_config(8'd255, 16'd1);
            2:       apply_config(8'd0, 16'd0);
            3:       apply_config(8'd3, 16'd7);
            default: apply_config(CYCLE_W'($urandom_range(0, 5)),
                                  TIMER_W'($urandom_range(1, 10)));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (TICKS_PER_PHASE) begin
            next_tick(t);
            send_tick(t);
         end
      end
      no_idle = 1'b0;

      // cycle count saturates at 255 on a steady climb, then a flat tick ends it
      apply_config(8'd255, 16'd1);
      for (k = 1; k <= 300; k++)
         send_tick(tick_of(16'hFFFF, VOLT_W'(k), ST_CHARGING, 1'b0));
      repeat (2) send_tick(tick_of(16'hFFFF, 16'd300, ST_CHARGING, 1'b0));

      settle();
      if (mismatches == 0 && open_ticks == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
